// ===== src/lbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lbsa_pkg: shared types and constants of the line block splitter
// Holds the byte classification item, the result record and the
// checksum constants used by the front, the queue and the back end.
// ----------------------------------------------------------------------------
package lbsa_pkg;

  // Largest number of bytes in one block (1 to 256).
  localparam int unsigned MaxBlock      = 256;
  // Default number of entries in the queue between front and back end.
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0]  NewlineByte = 8'h0a;
  localparam logic [15:0] AdlerMod    = 16'hfff1;

  localparam int unsigned LenW = 9;

  // One classified byte as it travels from the front to the back end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
    logic       is_newline;
  } item_t;

  // One finished block.
  typedef struct packed {
    logic [31:0]     block_offset;
    logic [LenW-1:0] block_length;
    logic [31:0]     block_checksum;
    logic [31:0]     blocks_so_far;
    logic            final_block;
  } result_t;

endpackage

// ===== src/lbsa_if.sv =====
// ----------------------------------------------------------------------------
// lbsa_if: byte and block channels of the line block splitter
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface lbsa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface lbsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_offset;
  logic [8:0]  block_length;
  logic [31:0] block_checksum;
  logic [31:0] blocks_so_far;
  logic        final_block;

  modport source (output valid, output block_offset, output block_length,
                  output block_checksum, output blocks_so_far, output final_block,
                  input ready);
  modport sink   (input valid, input block_offset, input block_length,
                  input block_checksum, input blocks_so_far, input final_block,
                  output ready);
endinterface

// ===== src/lbsa_front.sv =====
// ----------------------------------------------------------------------------
// lbsa_front: input stage of the line block splitter
// Registers each incoming byte and marks newline bytes for the back end.
// ----------------------------------------------------------------------------
module lbsa_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  lbsa_in_if.sink         byte_i,
  output logic            item_valid_o,
  output lbsa_pkg::item_t item_o,
  input  logic            item_ready_i
);
  import lbsa_pkg::*;

  logic  stg_valid_q, stg_valid_d;
  item_t stg_q;
  logic  take;

  // The stage refills whenever it is empty or drains in the same cycle.
  assign byte_i.ready = !stg_valid_q || item_ready_i;
  assign take         = byte_i.valid && byte_i.ready;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (take) begin
      stg_valid_d = 1'b1;
    end else if (item_ready_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stg_q.data_byte   <= byte_i.data_byte;
      stg_q.end_of_data <= byte_i.end_of_data;
      stg_q.is_newline  <= (byte_i.data_byte == NewlineByte);
    end
  end

  assign item_valid_o = stg_valid_q;
  assign item_o       = stg_q;

endmodule

// ===== src/lbsa_queue.sv =====
// ----------------------------------------------------------------------------
// lbsa_queue: short queue between front and back end
// Circular buffer of classified bytes with an occupancy count.
// ----------------------------------------------------------------------------
module lbsa_queue #(
  parameter int unsigned DEPTH = lbsa_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  lbsa_pkg::item_t push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output lbsa_pkg::item_t pop_item_o,
  input  logic            pop_ready_i
);
  import lbsa_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  // The count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  // Pointers stay apart by exactly the count (modulo the depth); this checks the empty case.
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wptr_q == rptr_q))
    else $error("queue empty but pointers differ");

endmodule

// ===== src/lbsa_back.sv =====
// ----------------------------------------------------------------------------
// lbsa_back: block accumulator of the line block splitter
// Keeps the running checksum, length, offset and block count, and holds
// each finished block in an output register until it is taken.
// ----------------------------------------------------------------------------
module lbsa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  lbsa_pkg::item_t item_i,
  output logic            item_ready_o,
  lbsa_out_if.source      block_o
);
  import lbsa_pkg::*;

  logic [15:0]     sum_low_q, sum_low_d;
  logic [15:0]     sum_high_q, sum_high_d;
  logic [LenW-1:0] len_q, len_d;
  logic [31:0]     start_q, start_d;
  logic [31:0]     pos_q, pos_d;
  logic [31:0]     cnt_q, cnt_d;
  logic            res_valid_q, res_valid_d;
  result_t         res_q;

  logic [15:0]     sl_add;
  logic [16:0]     sh_sum, sh_red1, sh_red2;
  logic [LenW-1:0] len_next;
  logic [31:0]     pos_next, cnt_next;
  logic            ends, out_free, take;

  // Checksum step: sum1 adds the byte, sum2 adds the new sum1 and is brought
  // back below the modulus with up to two conditional subtractions.
  assign sl_add  = sum_low_q + {8'h00, item_i.data_byte};
  assign sh_sum  = {1'b0, sum_high_q} + {1'b0, sl_add};
  assign sh_red1 = (sh_sum >= {1'b0, AdlerMod}) ? sh_sum - {1'b0, AdlerMod} : sh_sum;
  assign sh_red2 = (sh_red1 >= {1'b0, AdlerMod}) ? sh_red1 - {1'b0, AdlerMod} : sh_red1;

  assign len_next = len_q + LenW'(1);
  assign pos_next = pos_q + 32'd1;
  assign cnt_next = cnt_q + 32'd1;
  assign ends     = item_i.end_of_data || item_i.is_newline || (len_next >= LenW'(MaxBlock));

  // A byte that does not close a block never waits on the output register.
  assign out_free     = !res_valid_q || block_o.ready;
  assign item_ready_o = !ends || out_free;
  assign take         = item_valid_i && item_ready_o;

  always_comb begin
    sum_low_d   = sum_low_q;
    sum_high_d  = sum_high_q;
    len_d       = len_q;
    start_d     = start_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    res_valid_d = res_valid_q && !block_o.ready;
    if (take) begin
      if (ends) begin
        sum_low_d   = 16'd1;
        sum_high_d  = 16'd0;
        len_d       = '0;
        res_valid_d = 1'b1;
        if (item_i.end_of_data) begin
          start_d = 32'd0;
          pos_d   = 32'd0;
          cnt_d   = 32'd0;
        end else begin
          start_d = pos_next;
          pos_d   = pos_next;
          cnt_d   = cnt_next;
        end
      end else begin
        sum_low_d  = sl_add;
        sum_high_d = sh_red2[15:0];
        len_d      = len_next;
        pos_d      = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_low_q   <= 16'd1;
      sum_high_q  <= 16'd0;
      len_q       <= '0;
      start_q     <= 32'd0;
      pos_q       <= 32'd0;
      cnt_q       <= 32'd0;
      res_valid_q <= 1'b0;
    end else begin
      sum_low_q   <= sum_low_d;
      sum_high_q  <= sum_high_d;
      len_q       <= len_d;
      start_q     <= start_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ends) begin
      res_q.block_offset   <= start_q;
      res_q.block_length   <= len_next;
      res_q.block_checksum <= {sh_red2[15:0], sl_add};
      res_q.blocks_so_far  <= cnt_next;
      res_q.final_block    <= item_i.end_of_data;
    end
  end

  assign block_o.valid          = res_valid_q;
  assign block_o.block_offset   = res_q.block_offset;
  assign block_o.block_length   = res_q.block_length;
  assign block_o.block_checksum = res_q.block_checksum;
  assign block_o.blocks_so_far  = res_q.blocks_so_far;
  assign block_o.final_block    = res_q.final_block;

  // sum2 is always kept reduced.
  a_sum_high_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_high_q < AdlerMod)
    else $error("sum2 not reduced");

  // An open block is always shorter than the block limit.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q < LenW'(MaxBlock))
    else $error("open block length at or above limit");

  // A pending result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !block_o.ready) |-> !(take && ends))
    else $error("pending block overwritten");

  // The final byte starts new data at offset zero with a fresh count.
  a_final_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.end_of_data) |=> (pos_q == 32'd0 && cnt_q == 32'd0 && start_q == 32'd0))
    else $error("data counters not cleared after final byte");

endmodule

// ===== src/line_block_splitter_adler32_core.sv =====
// ----------------------------------------------------------------------------
// line_block_splitter_adler32_core: byte stream to checksummed blocks
// Cuts a byte stream into blocks that end after a newline, at the block
// size limit, or at the last byte of the data, and reports each block's
// offset, length, running count and Adler-style checksum.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake    Payload
//   byte_i    in   valid/ready  data_byte[7:0], end_of_data
//   block_o   out  valid/ready  block_offset[31:0], block_length[8:0],
//                               block_checksum[31:0], blocks_so_far[31:0],
//                               final_block
//
// One byte is taken per clock cycle for as long as the block channel keeps
// up; this rate is set by the checksum update (one 16-bit add for sum1, one
// add and two conditional subtracts for sum2) in the back end.
// A block appears on block_o after its last byte has passed through the input
// stage, the queue and the output register, in that order; a full queue or a
// block still pending on block_o can hold it on the way.
// After reset the block is ready at once: all counters start cleared, sum1
// at one, and no memory needs a clearing pass.
// A stall on block_o only blocks a byte that would close another block; the
// input stage and the queue keep absorbing bytes until they fill.
//
module line_block_splitter_adler32_core #(
  parameter int unsigned QUEUE_DEPTH = lbsa_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbsa_in_if.sink     byte_i,
  lbsa_out_if.source  block_o
);
  import lbsa_pkg::*;

  // Front to queue.
  logic  fr_valid;
  logic  fr_ready;
  item_t fr_item;

  // Queue to back end.
  logic  bk_valid;
  logic  bk_ready;
  item_t bk_item;

  // The front registers each byte and marks newlines so that the back end
  // does not have to compare the byte on its critical path.
  lbsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .item_valid_o (fr_valid),
    .item_o       (fr_item),
    .item_ready_i (fr_ready)
  );

  // The queue decouples the two halves so that a short stall on the result
  // side does not reach back to the byte channel at once.
  lbsa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_item_i  (fr_item),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_item_o   (bk_item),
    .pop_ready_i  (bk_ready)
  );

  // The back end keeps all per-block and per-data state and owns the
  // output register of the block channel.
  lbsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_i       (bk_item),
    .item_ready_o (bk_ready),
    .block_o      (block_o)
  );

endmodule
